### hw/rtl/pl0_token_scanner_assert.svh
// Assertion macros used by the token scanner checker.
`ifndef PL0_TOKEN_SCANNER_ASSERT_SVH
`define PL0_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PL0TS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pl0ts assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PL0TS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pl0ts assertion failed");

// Next-cycle implication that also holds across reset.
`define PL0TS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pl0ts assertion failed");

`endif

### hw/rtl/pl0ts_pkg.sv
// Package with types, token codes and keyword tables of the token scanner.
package pl0ts_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 127;
  localparam int PREFIX_DEPTH = 9;
  localparam int KW_COUNT = 11;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COLON,
    MODE_LESS,
    MODE_GREATER,
    MODE_COMMENT
  } scan_mode_t;

  typedef enum logic [4:0] {
    TK_IDENT        = 5'd0,
    TK_NUMBER       = 5'd1,
    TK_PLUS         = 5'd2,
    TK_MINUS        = 5'd3,
    TK_TIMES        = 5'd4,
    TK_SLASH        = 5'd5,
    TK_EQL          = 5'd6,
    TK_NEQ          = 5'd7,
    TK_LSS          = 5'd8,
    TK_LEQ          = 5'd9,
    TK_GTR          = 5'd10,
    TK_GEQ          = 5'd11,
    TK_SEMI         = 5'd12,
    TK_PERIOD       = 5'd13,
    TK_BECOMES      = 5'd14,
    TK_ERROR        = 5'd15,
    TK_KW_CONST     = 5'd16,
    TK_KW_VAR       = 5'd17,
    TK_KW_PROCEDURE = 5'd18,
    TK_KW_CALL      = 5'd19,
    TK_KW_BEGIN     = 5'd20,
    TK_KW_END       = 5'd21,
    TK_KW_IF        = 5'd22,
    TK_KW_THEN      = 5'd23,
    TK_KW_WHILE     = 5'd24,
    TK_KW_DO        = 5'd25,
    TK_KW_ODD       = 5'd26,
    TK_OPEN_COMMENT = 5'd27
  } tok_kind_t;

  typedef logic [0:PREFIX_DEPTH-1][7:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    {"CONST", 32'h0},
    {"VAR", 48'h0},
    "PROCEDURE",
    {"CALL", 40'h0},
    {"BEGIN", 32'h0},
    {"END", 48'h0},
    {"IF", 56'h0},
    {"THEN", 40'h0},
    {"WHILE", 32'h0},
    {"DO", 56'h0},
    {"ODD", 48'h0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [6:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_pair_t;

endpackage

### hw/rtl/pl0ts_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
interface pl0ts_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] source_byte;

  modport source (output valid, op, source_byte, input ready);
  modport sink (input valid, op, source_byte, output ready);
endinterface

interface pl0ts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [6:0]  token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, token_start, token_length, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, token_start, token_length, last_of_run,
                output ready);
endinterface

### hw/rtl/pl0_token_scanner.sv
// Top level of the PL/0 token scanner: input register, scan step and token buffer.
// Throughput: one source byte per cycle while the token buffer has room; a byte
// that yields two tokens holds the input until the first of them is sent, set by
// the single token beat per cycle on the output.
// Reset clears the scan state, the byte offset and both channel registers at once.
module pl0_token_scanner import pl0ts_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pl0ts_in_if.sink    src,
  pl0ts_out_if.source tok
);

  logic in_valid;
  logic in_op;
  logic [7:0] in_byte;
  logic adv;
  logic room;
  tok_pair_t pair;

  assign adv = in_valid && room;
  assign src.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (src.ready) begin
      in_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      in_op <= src.op;
      in_byte <= src.source_byte;
    end
  end

  pl0ts_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .op(in_op),
    .source_byte(in_byte),
    .pair(pair)
  );

  pl0ts_obuf u_obuf (
    .clk(clk),
    .rst(rst),
    .load(adv),
    .pair(pair),
    .room(room),
    .tok(tok)
  );

endmodule

### hw/rtl/pl0ts_core.sv
// Scanner state and per-byte step logic that yields up to two tokens.
module pl0ts_core import pl0ts_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       op,
  input  logic [7:0] source_byte,
  output tok_pair_t  pair
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int PIDX_W = $clog2(PREFIX_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_PREFIX = LEN_W'(PREFIX_DEPTH);

  scan_mode_t mode;
  scan_mode_t mode_next;
  logic [LEN_W-1:0] pending_length;
  logic [LEN_W-1:0] pending_length_next;
  logic [31:0] pending_start;
  logic [31:0] pending_start_next;
  logic [31:0] byte_offset;
  logic [31:0] byte_offset_next;
  logic [7:0] word_prefix [PREFIX_DEPTH];

  logic [7:0] c;
  logic is_alpha;
  logic is_digit;
  logic is_space;
  logic cont_raw;
  logic cont;
  logic fresh;
  logic flush;
  logic starts_token;
  logic fresh_valid;
  logic flush_valid;
  logic cont_valid;
  logic prefix_we;
  logic [PIDX_W-1:0] prefix_idx;
  logic [LEN_W-1:0] len_grown;
  logic [KW_COUNT-1:0] kw_hit;
  tok_kind_t word_kind;
  tok_kind_t fresh_kind;
  token_t flush_tok;
  token_t cont_tok;
  token_t fresh_tok;

  assign c = source_byte;
  assign is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit = c >= "0" && c <= "9";
  assign is_space = c == " " || (c >= 8'd9 && c <= 8'd13);
  assign len_grown = (pending_length < LEN_MAX) ? pending_length + LEN_ONE : LEN_MAX;

  always_comb begin
    case (mode)
      MODE_IDENT:   cont_raw = is_alpha || is_digit;
      MODE_NUMBER:  cont_raw = is_digit;
      MODE_COLON:   cont_raw = c == "=";
      MODE_LESS:    cont_raw = c == ">" || c == "=";
      MODE_GREATER: cont_raw = c == "=";
      MODE_COMMENT: cont_raw = 1'b1;
      default:      cont_raw = 1'b0;
    endcase
  end

  assign cont = !op && cont_raw;
  assign fresh = !op && !cont_raw;
  assign flush = op || !cont_raw;
  assign starts_token = c == "{" || is_space || c == "," || is_alpha || is_digit ||
                        c == ":" || c == "<" || c == ">";

  always_comb begin
    kw_hit = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_hit[k] = pending_length == LEN_W'(KW_LEN[k]);
      for (int i = 0; i < PREFIX_DEPTH; i++) begin
        if (4'(i) < KW_LEN[k] && word_prefix[i] != KW_TEXT[k][i]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    word_kind = TK_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        word_kind = tok_kind_t'(5'(TK_KW_CONST) + 5'(k));
      end
    end
  end

  always_comb begin
    case (c)
      "+":     fresh_kind = TK_PLUS;
      "-":     fresh_kind = TK_MINUS;
      "*":     fresh_kind = TK_TIMES;
      "/":     fresh_kind = TK_SLASH;
      "=":     fresh_kind = TK_EQL;
      ";":     fresh_kind = TK_SEMI;
      ".":     fresh_kind = TK_PERIOD;
      default: fresh_kind = TK_ERROR;
    endcase
  end

  always_comb begin
    mode_next = mode;
    if (op) begin
      mode_next = MODE_IDLE;
    end else if (cont_raw) begin
      case (mode)
        MODE_IDENT:   mode_next = MODE_IDENT;
        MODE_NUMBER:  mode_next = MODE_NUMBER;
        MODE_COMMENT: mode_next = (c == "}") ? MODE_IDLE : MODE_COMMENT;
        default:      mode_next = MODE_IDLE;
      endcase
    end else if (c == "{") begin
      mode_next = MODE_COMMENT;
    end else if (is_alpha) begin
      mode_next = MODE_IDENT;
    end else if (is_digit) begin
      mode_next = MODE_NUMBER;
    end else if (c == ":") begin
      mode_next = MODE_COLON;
    end else if (c == "<") begin
      mode_next = MODE_LESS;
    end else if (c == ">") begin
      mode_next = MODE_GREATER;
    end else begin
      mode_next = MODE_IDLE;
    end
  end

  always_comb begin
    flush_tok.start = pending_start;
    flush_tok.last = 1'b0;
    flush_tok.length = 7'd1;
    case (mode)
      MODE_IDENT: begin
        flush_tok.kind = word_kind;
        flush_tok.length = 7'(pending_length);
      end
      MODE_NUMBER: begin
        flush_tok.kind = TK_NUMBER;
        flush_tok.length = 7'(pending_length);
      end
      MODE_COLON:   flush_tok.kind = TK_ERROR;
      MODE_LESS:    flush_tok.kind = TK_LSS;
      MODE_GREATER: flush_tok.kind = TK_GTR;
      MODE_COMMENT: begin
        flush_tok.kind = TK_OPEN_COMMENT;
        flush_tok.length = 7'(pending_length);
      end
      default:      flush_tok.kind = TK_IDENT;
    endcase
    flush_valid = flush && mode != MODE_IDLE;

    cont_tok.start = pending_start;
    cont_tok.length = 7'd2;
    cont_tok.last = 1'b0;
    case (mode)
      MODE_COLON:   cont_tok.kind = TK_BECOMES;
      MODE_LESS:    cont_tok.kind = (c == ">") ? TK_NEQ : TK_LEQ;
      default:      cont_tok.kind = TK_GEQ;
    endcase
    cont_valid = cont && (mode == MODE_COLON || mode == MODE_LESS || mode == MODE_GREATER);

    fresh_tok.kind = fresh_kind;
    fresh_tok.start = byte_offset;
    fresh_tok.length = 7'd1;
    fresh_tok.last = 1'b1;
    fresh_valid = fresh && !starts_token;

    pair.count = 2'(flush_valid) + 2'(cont_valid) + 2'(fresh_valid);
    if (flush_valid) begin
      pair.first = flush_tok;
    end else if (cont_valid) begin
      pair.first = cont_tok;
    end else begin
      pair.first = fresh_tok;
    end
    pair.first.last = pair.count == 2'd1;
    pair.second = fresh_tok;

    pending_length_next = pending_length;
    pending_start_next = pending_start;
    byte_offset_next = byte_offset + 32'd1;
    if (op) begin
      pending_length_next = '0;
      pending_start_next = '0;
      byte_offset_next = '0;
    end else if (cont) begin
      if (mode == MODE_IDENT || mode == MODE_NUMBER ||
          (mode == MODE_COMMENT && c != "}")) begin
        pending_length_next = len_grown;
      end
    end else begin
      if (c == "{" || is_alpha || is_digit) begin
        pending_length_next = LEN_ONE;
      end
      if (c == "{" || is_alpha || is_digit || c == ":" || c == "<" || c == ">") begin
        pending_start_next = byte_offset;
      end
    end

    prefix_we = (cont && mode == MODE_IDENT && pending_length < LEN_PREFIX) ||
                (fresh && is_alpha);
    prefix_idx = fresh ? '0 : pending_length[PIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pending_length <= '0;
      pending_start <= '0;
      byte_offset <= '0;
    end else if (adv) begin
      mode <= mode_next;
      pending_length <= pending_length_next;
      pending_start <= pending_start_next;
      byte_offset <= byte_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && prefix_we) begin
      word_prefix[prefix_idx] <= c;
    end
  end

endmodule

### hw/rtl/pl0ts_obuf.sv
// Two-entry token buffer: loads a step's tokens, sends one beat per cycle if ready.
module pl0ts_obuf import pl0ts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  tok_pair_t   pair,
  output logic        room,
  pl0ts_out_if.source tok
);

  logic [1:0] count;
  token_t slot [2];
  logic pop;

  assign pop = count != 2'd0 && tok.ready;
  assign room = count == 2'd0 || (count == 2'd1 && tok.ready);

  assign tok.valid = count != 2'd0;
  assign tok.token_kind = slot[0].kind;
  assign tok.token_start = slot[0].start;
  assign tok.token_length = slot[0].length;
  assign tok.last_of_run = slot[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pair.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= pair.first;
      slot[1] <= pair.second;
    end else if (pop) begin
      slot[0] <= slot[1];
    end
  end

endmodule

### hw/rtl/pl0ts_checker.sv
// Port-level checker for the token scanner and its bind to the top level.
`include "pl0_token_scanner_assert.svh"

module pl0ts_checker import pl0ts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        src_ready,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [4:0]  tok_kind,
  input logic [31:0] tok_start,
  input logic [6:0]  tok_length,
  input logic        tok_last
);

  `PL0TS_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !tok_valid && src_ready)

  `PL0TS_ASSERT_NEXT(a_stall_holds, clk, rst, tok_valid && !tok_ready, tok_valid && $stable(tok_kind) && $stable(tok_start) && $stable(tok_length) && $stable(tok_last))

  `PL0TS_ASSERT_IMP(a_open_comment_last, clk, rst, tok_valid && tok_kind == 5'(TK_OPEN_COMMENT), tok_last)

  `PL0TS_ASSERT_IMP(a_pair_op_shape, clk, rst, tok_valid && (tok_kind == 5'(TK_BECOMES) || tok_kind == 5'(TK_NEQ) || tok_kind == 5'(TK_LEQ) || tok_kind == 5'(TK_GEQ)), tok_length == 7'd2 && tok_last)

endmodule

bind pl0_token_scanner pl0ts_checker u_pl0ts_checker (
  .clk(clk),
  .rst(rst),
  .src_ready(src.ready),
  .tok_valid(tok.valid),
  .tok_ready(tok.ready),
  .tok_kind(tok.token_kind),
  .tok_start(tok.token_start),
  .tok_length(tok.token_length),
  .tok_last(tok.last_of_run)
);
